// ===== hdl/jsu_pkg.sv =====
// Shared types and constants of the JSON string unescape unit.
package jsu_pkg;

   // Most results that one request can cause: four UTF-8 bytes and a status.
   localparam int MaxResults = 5;
   localparam int CountWidth = $clog2(MaxResults + 1);

   // Status codes of a result.
   typedef enum logic [2:0] {
      StData       = 3'd0,
      StDone       = 3'd1,
      StNoQuote    = 3'd2,
      StUnterm     = 3'd3,
      StOpenEsc    = 3'd4,
      StBadEsc     = 3'd5,
      StBadHex     = 3'd6,
      StBadPair    = 3'd7
   } status_type;

   // The results of one request, in output order; entries at count and above are unused.
   typedef struct packed {
      logic [CountWidth-1:0]            count;
      logic [MaxResults-1:0][7:0]       data;
      status_type [MaxResults-1:0]      status;
   } burst_type;

endpackage

// ===== hdl/jsu_decode.sv =====
// Parser state and single-pass decode of one request into its list of results.
module jsu_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic [7:0]         in_byte,
   input  logic               in_end,
   output jsu_pkg::burst_type burst
);

   typedef enum logic [3:0] {
      ModeQuote  = 4'd0,
      ModeStr    = 4'd1,
      ModeEsc    = 4'd2,
      ModeHex1   = 4'd3,
      ModePairBs = 4'd4,
      ModePairU  = 4'd5,
      ModeHex2   = 4'd6,
      ModeDrain  = 4'd7
   } mode_type;

   localparam logic [7:0] ChQuote     = 8'h22;
   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChSlash     = 8'h2F;
   localparam logic [7:0] ChB         = 8'h62;
   localparam logic [7:0] ChF         = 8'h66;
   localparam logic [7:0] ChN         = 8'h6E;
   localparam logic [7:0] ChR         = 8'h72;
   localparam logic [7:0] ChT         = 8'h74;
   localparam logic [7:0] ChU         = 8'h75;

   mode_type    mode_ff, mode_in;
   logic [15:0] accum_ff, accum_in;
   logic [1:0]  count_ff, count_in;
   logic [9:0]  high_ff, high_in;

   // Append one result to a list.
   function automatic jsu_pkg::burst_type add_entry(input jsu_pkg::burst_type r,
                                                    input logic [7:0] b,
                                                    input jsu_pkg::status_type s);
      jsu_pkg::burst_type t;
      t = r;
      t.data[t.count]   = b;
      t.status[t.count] = s;
      t.count           = t.count + jsu_pkg::CountWidth'(1);
      return t;
   endfunction

   // Append the UTF-8 encoding of a code point, one to four bytes.
   function automatic jsu_pkg::burst_type add_code_point(input jsu_pkg::burst_type r,
                                                         input logic [20:0] cp);
      jsu_pkg::burst_type t;
      t = r;
      if (cp[20:7] == '0) begin
         t = add_entry(t, cp[7:0], jsu_pkg::StData);
      end else if (cp[20:11] == '0) begin
         t = add_entry(t, {3'b110, cp[10:6]}, jsu_pkg::StData);
         t = add_entry(t, {2'b10, cp[5:0]}, jsu_pkg::StData);
      end else if (cp[20:16] == '0) begin
         t = add_entry(t, {4'b1110, cp[15:12]}, jsu_pkg::StData);
         t = add_entry(t, {2'b10, cp[11:6]}, jsu_pkg::StData);
         t = add_entry(t, {2'b10, cp[5:0]}, jsu_pkg::StData);
      end else begin
         t = add_entry(t, {5'b11110, cp[20:18]}, jsu_pkg::StData);
         t = add_entry(t, {2'b10, cp[17:12]}, jsu_pkg::StData);
         t = add_entry(t, {2'b10, cp[11:6]}, jsu_pkg::StData);
         t = add_entry(t, {2'b10, cp[5:0]}, jsu_pkg::StData);
      end
      return t;
   endfunction

   // Hex digit of either case: valid flag above the 4-bit value.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, 4'(b[3:0] + 4'd9)};
      end
      return r;
   endfunction

   // Decode the request against the current state.
   always_comb begin : decode
      jsu_pkg::burst_type r;
      logic               stop;
      logic [4:0]         hd;
      logic [15:0]        v;

      r        = '0;
      stop     = 1'b0;
      hd       = hex_digit(in_byte);
      v        = {accum_ff[11:0], hd[3:0]};
      mode_in  = mode_ff;
      accum_in = accum_ff;
      count_in = count_ff;
      high_in  = high_ff;

      case (mode_ff)
         ModeQuote: begin
            if (in_byte == ChQuote) begin
               mode_in = ModeStr;
            end else begin
               r    = add_entry(r, 8'h00, jsu_pkg::StNoQuote);
               stop = 1'b1;
            end
         end
         ModeStr: begin
            if (in_byte == ChQuote) begin
               r    = add_entry(r, 8'h00, jsu_pkg::StDone);
               stop = 1'b1;
            end else if (in_byte == ChBackslash) begin
               mode_in = ModeEsc;
            end else begin
               r = add_entry(r, in_byte, jsu_pkg::StData);
            end
         end
         ModeEsc: begin
            mode_in = ModeStr;
            case (in_byte)
               ChQuote, ChBackslash, ChSlash: r = add_entry(r, in_byte, jsu_pkg::StData);
               ChB: r = add_entry(r, 8'h08, jsu_pkg::StData);
               ChF: r = add_entry(r, 8'h0C, jsu_pkg::StData);
               ChN: r = add_entry(r, 8'h0A, jsu_pkg::StData);
               ChR: r = add_entry(r, 8'h0D, jsu_pkg::StData);
               ChT: r = add_entry(r, 8'h09, jsu_pkg::StData);
               ChU: begin
                  accum_in = '0;
                  count_in = '0;
                  mode_in  = ModeHex1;
               end
               default: begin
                  r    = add_entry(r, 8'h00, jsu_pkg::StBadEsc);
                  stop = 1'b1;
               end
            endcase
         end
         ModeHex1, ModeHex2: begin
            if (!hd[4]) begin
               r    = add_entry(r, 8'h00, (mode_ff == ModeHex1) ? jsu_pkg::StBadHex
                                                             : jsu_pkg::StBadPair);
               stop = 1'b1;
            end else begin
               accum_in = v;
               if (count_ff != 2'd3) begin
                  count_in = count_ff + 2'd1;
               end else begin
                  // Fourth digit: the escape's value is complete.
                  count_in = '0;
                  if (mode_ff == ModeHex1) begin
                     if (v[15:10] == 6'b110110) begin
                        high_in = v[9:0];
                        mode_in = ModePairBs;
                     end else begin
                        r       = add_code_point(r, {5'b0, v});
                        mode_in = ModeStr;
                     end
                  end else begin
                     if (v[15:10] == 6'b110111) begin
                        r       = add_code_point(r, 21'h10000 + {1'b0, high_ff, v[9:0]});
                        mode_in = ModeStr;
                     end else begin
                        r    = add_entry(r, 8'h00, jsu_pkg::StBadPair);
                        stop = 1'b1;
                     end
                  end
               end
            end
         end
         ModePairBs: begin
            if (in_byte == ChBackslash) begin
               mode_in = ModePairU;
            end else begin
               r    = add_entry(r, 8'h00, jsu_pkg::StBadPair);
               stop = 1'b1;
            end
         end
         ModePairU: begin
            if (in_byte == ChU) begin
               accum_in = '0;
               count_in = '0;
               mode_in  = ModeHex2;
            end else begin
               r    = add_entry(r, 8'h00, jsu_pkg::StBadPair);
               stop = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // A failure or the closing quote drops the rest of the text; otherwise the
      // end of text reports where the string was left open.
      if (stop) begin
         mode_in = ModeDrain;
      end else if (in_end) begin
         case (mode_in)
            ModeStr:  r = add_entry(r, 8'h00, jsu_pkg::StUnterm);
            ModeEsc:  r = add_entry(r, 8'h00, jsu_pkg::StOpenEsc);
            ModeHex1: r = add_entry(r, 8'h00, jsu_pkg::StBadHex);
            ModePairBs, ModePairU, ModeHex2: r = add_entry(r, 8'h00, jsu_pkg::StBadPair);
            default: begin
            end
         endcase
      end

      if (in_end) begin
         mode_in  = ModeQuote;
         accum_in = '0;
         count_in = '0;
         high_in  = '0;
      end

      burst = r;
   end

   // Parser state advances on each request handed to the output queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ModeQuote;
         accum_ff <= '0;
         count_ff <= '0;
         high_ff  <= '0;
      end else if (load) begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
         count_ff <= count_in;
         high_ff  <= high_in;
      end
   end

   // The end of text always returns the parser to the opening quote.
   assert property (@(posedge clock) disable iff (reset)
      (load && in_end) |=> (mode_ff == ModeQuote && count_ff == 2'd0))
      else $error("parser not rearmed after end of text");

endmodule

// ===== hdl/jsu_burst.sv =====
// Output queue that delivers the results of one request one per cycle while the receiver does not stall.
module jsu_burst (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  jsu_pkg::burst_type burst,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic [2:0]         rsp_status,
   output logic               rsp_run_last
);

   logic [jsu_pkg::CountWidth-1:0]             cnt_ff;
   logic [jsu_pkg::MaxResults-1:0][7:0]        data_ff;
   jsu_pkg::status_type [jsu_pkg::MaxResults-1:0] status_ff;
   logic                                       take;

   assign take = rsp_valid && !rsp_stall;

   // Room for a new list when empty or when the last entry leaves now.
   assign free = (cnt_ff == '0) || (cnt_ff == jsu_pkg::CountWidth'(1) && !rsp_stall);

   // Count of waiting entries.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= burst.count;
      end else if (take) begin
         cnt_ff <= cnt_ff - jsu_pkg::CountWidth'(1);
      end
   end

   // Entries shift toward the head as they are taken.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff   <= burst.data;
         status_ff <= burst.status;
      end else if (take) begin
         for (int i = 0; i < jsu_pkg::MaxResults - 1; i++) begin
            data_ff[i]   <= data_ff[i+1];
            status_ff[i] <= status_ff[i+1];
         end
      end
   end

   assign rsp_valid    = (cnt_ff != '0);
   assign rsp_out_byte = data_ff[0];
   assign rsp_status   = status_ff[0];
   assign rsp_run_last = (cnt_ff == jsu_pkg::CountWidth'(1));

   // A done or error status is always the final result of its request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != jsu_pkg::StData) |-> rsp_run_last)
      else $error("status result not last of its request");

   // A new list is only taken once the previous one has drained.
   assert property (@(posedge clock) disable iff (reset)
      load |-> (cnt_ff == '0 || (cnt_ff == jsu_pkg::CountWidth'(1) && take)))
      else $error("result list overwritten before delivery");

   // A delivered entry without a new list lowers the count by one.
   assert property (@(posedge clock) disable iff (reset)
      (take && !load) |=> cnt_ff == $past(cnt_ff) - jsu_pkg::CountWidth'(1))
      else $error("queue count out of step");

endmodule

// ===== hdl/json_string_unescape_utf8_unit.sv =====
// Top level of the JSON string unescape unit: input register, decoder and output queue.
//
// Requests carry one byte of JSON text (req_in_byte) and an end-of-text flag
// (req_in_end), starting with the string's opening quote. Each request yields
// zero to five results on the rsp_ channel: decoded UTF-8 bytes with status 0,
// or one done or error status; rsp_run_last marks the final result of a request.
// After done or an error, bytes are dropped until the end-of-text request.
// A request is taken when valid is high and stall is low, on both channels.
// The first result of a request passes from the input register to the result
// queue, loaded by the decoder, and is presented at the queue head to be taken.
// Requests are accepted one per cycle while each yields at most one result and
// the receiver does not stall; a request with several results holds the queue
// until all of them are taken, while the next waits in the input register.
// The single output queue sets this limit.
// When the receiver stalls, the head result holds and req_stall rises as soon
// as the input register is occupied and the queue cannot drain.
// Synchronous reset empties the input register and the queue and returns the
// parser to awaiting an opening quote.
module json_string_unescape_utf8_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_status,
   output logic       rsp_run_last
);

   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               in_end_ff;
   logic               free;
   logic               load;
   jsu_pkg::burst_type burst;

   // Hand the registered request to the queue when it has room.
   assign load      = in_valid_ff && free;
   assign req_stall = in_valid_ff && !free;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
         in_end_ff  <= req_in_end;
      end
   end

   jsu_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .in_byte (in_byte_ff),
      .in_end  (in_end_ff),
      .burst   (burst)
   );

   jsu_burst u_burst (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .burst        (burst),
      .free         (free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_run_last (rsp_run_last)
   );

   // A held request stays in the input register until the queue takes it.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !load) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_end_ff)))
      else $error("held request lost from input register");

endmodule
